// ===== design/ybtn_pkg.sv =====
`default_nettype none
package ybtn_pkg;

	typedef enum logic [3:0] {
		S_LOAD,
		S_KEY,
		S_INS_RD,
		S_INS_CMP,
		S_NMS_INIT,
		S_NEXT_I,
		S_CLS,
		S_FIND,
		S_FIND_END,
		S_EMIT,
		S_SUP,
		S_DONE
	} state_t;

	localparam int CFG_IDX_WIDTH = 2;
	localparam int CFG_WIDTH     = 9;
	localparam int NCH_WIDTH     = 8;
	localparam int CLASS_WIDTH   = 7;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_CONF  = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_NMS   = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_NCH   = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ANGLE = 2'd3;

	localparam logic [CFG_WIDTH-1:0] CONF_RESET  = 9'd64;
	localparam logic [CFG_WIDTH-1:0] NMS_RESET   = 9'd115;
	localparam logic [NCH_WIDTH-1:0] NCH_RESET   = 8'd85;

	localparam int RESULT_CAP   = 64;
	localparam int GEO_FIELDS   = 5;
	localparam int MIN_CHANNELS = 6;
	localparam int ANGLE_TAIL   = 7;
	// 30 degrees per bin and -90 degree offset, both in Q.8
	localparam int BIN_STEP     = 7680;
	localparam int ANGLE_OFS    = 23040;

endpackage
`default_nettype wire

// ===== design/yolo_box_threshold_nms_top.sv =====
// channel   signals                                   direction
// cfg       cfg_we, cfg_index, cfg_data               in, write only
// in        in_valid/in_ready, channel_value, last    in, one channel value per item
// out       out_valid/out_ready, box fields, flags    out, one kept box (or a none_found marker) per item
//
// loading takes one item per cycle while in_ready is high; a kept anchor then blocks input
// during its insertion into the box ram, which moves each stored box with a lower key up one slot
// at frame end, nms runs twice over the ram (count pass, then emit pass):
// each class pick is a find scan, then a suppression scan; a result waits for out_ready
// reset clears counters and the anchor; the box ram is not cleared
// input is held off (in_ready low) during insertion, nms and result output
`default_nettype none
module yolo_box_threshold_nms_top #(
	parameter int MAX_BOXES    = 64,
	parameter int MAX_CHANNELS = 128,
	parameter int VALUE_WIDTH  = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ybtn_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  wire logic [ybtn_pkg::CFG_WIDTH-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [VALUE_WIDTH-1:0]          channel_value,
	input  wire logic                                   last_in_frame,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [VALUE_WIDTH-1:0]               box_x,
	output logic signed [VALUE_WIDTH-1:0]               box_y,
	output logic signed [VALUE_WIDTH-1:0]               box_w,
	output logic signed [VALUE_WIDTH-1:0]               box_h,
	output logic signed [VALUE_WIDTH-1:0]               objectness,
	output logic [ybtn_pkg::CLASS_WIDTH-1:0]            class_index,
	output logic signed [VALUE_WIDTH-1:0]               class_score,
	output logic signed [VALUE_WIDTH-1:0]               angle_deg,
	output logic                                        none_found,
	output logic                                        overflow,
	output logic                                        last_result
);
	import ybtn_pkg::*;

	localparam int VW   = VALUE_WIDTH;
	localparam int AW   = $clog2(MAX_BOXES);
	localparam int CNTW = AW + 1;
	localparam int CW   = $clog2(MAX_CHANNELS);
	localparam int CIW  = (CW > CLASS_WIDTH) ? CW : CLASS_WIDTH;
	localparam int KW   = 2 * VW;
	localparam int GW   = VW + 3;
	localparam int PW   = 2 * GW;
	localparam int LW   = PW + 12;
	localparam int AGW  = VW + 8;
	localparam int NW   = $clog2(RESULT_CAP + 2);

	typedef struct packed {
		logic signed [VW-1:0]  x;
		logic signed [VW-1:0]  y;
		logic signed [VW-1:0]  w;
		logic signed [VW-1:0]  h;
		logic signed [VW-1:0]  obj;
		logic signed [VW-1:0]  cls;
		logic signed [VW-1:0]  ang;
		logic [CIW-1:0]        cidx;
		logic signed [KW-1:0]  key;
	} entry_t;

	state_t state_q, state_d;

	logic [CFG_WIDTH-1:0] conf_q, nms_q;
	logic [NCH_WIDTH-1:0] nch_q;
	logic                 angle_q;

	// current anchor
	logic signed [VW-1:0] geo_q [GEO_FIELDS];
	logic signed [VW-1:0] best_cls_q, best_bin_q, reg_q;
	logic [CIW-1:0]       cls_idx_q;
	logic [2:0]           bin_idx_q;
	logic                 cls_seen_q, bin_seen_q;
	logic [CW-1:0]        chan_q;

	logic [CNTW-1:0]      count_q, i_q, j_q, k_q;
	logic                 ovf_q, pend_q, pass_q, found_q;
	logic [NW-1:0]        n_q, tot_q;
	logic [MAX_BOXES-1:0] alive_q;
	logic                 v_s1, v_s2, v_s3;
	logic                 out_valid_q;

	entry_t mem [MAX_BOXES];
	entry_t rdata, new_q, best_q, wdata;
	logic   re, we;
	logic [AW-1:0] raddr, waddr;
	logic [AW-1:0] best_idx_q, j_s1, j_s2, j_s3;
	logic [CIW-1:0] cls_q;
	logic signed [KW-1:0] area_q, aj_s2;
	logic signed [GW-1:0] ow_s2, oh_s2;
	logic signed [PW-1:0] inter_s3, sum_s3;
	logic ok_s2, ok_s3;

	entry_t out_q;
	logic   out_none_q, out_ovf_q, out_last_q;

	// load path decode
	logic [8:0] ncl;
	logic [9:0] c10, n10;
	logic       in_acc, in_bin, in_reg, anchor_end, pass_conf, full;
	logic [8:0] nch9;

	always_comb begin
		nch9 = {1'b0, nch_q};
		if (nch9 < 9'(MIN_CHANNELS))
			ncl = 9'(MIN_CHANNELS);
		else if (nch9 > 9'(MAX_CHANNELS))
			ncl = 9'(MAX_CHANNELS);
		else
			ncl = nch9;
	end

	assign c10        = 10'(chan_q);
	assign n10        = 10'(ncl);
	assign in_acc     = in_valid && in_ready;
	assign in_bin     = angle_q && (c10 + 10'(ANGLE_TAIL) >= n10) && (c10 + 10'd1 < n10);
	assign in_reg     = angle_q && (c10 + 10'd1 == n10);
	assign anchor_end = (c10 + 10'd1 >= n10);
	assign pass_conf  = geo_q[4] > $signed({{(VW-CFG_WIDTH){1'b0}}, conf_q});
	assign full       = (count_q == CNTW'(MAX_BOXES));

	// angle decode and key
	logic signed [AGW-1:0] bin_x, reg_x, ang_sum;
	logic signed [VW-1:0]  ang_sat;
	logic signed [KW-1:0]  key_c;

	always_comb begin
		bin_x   = signed'(AGW'(bin_idx_q));
		reg_x   = AGW'(reg_q);
		ang_sum = bin_x * signed'(AGW'(BIN_STEP)) + (reg_x <<< 5) - (reg_x <<< 1)
			- signed'(AGW'(ANGLE_OFS));
		if (ang_sum[AGW-1:VW-1] == '0 || ang_sum[AGW-1:VW-1] == '1)
			ang_sat = ang_sum[VW-1:0];
		else if (ang_sum[AGW-1])
			ang_sat = {1'b1, {(VW-1){1'b0}}};
		else
			ang_sat = {1'b0, {(VW-1){1'b1}}};
		key_c = KW'(geo_q[4]) * KW'(best_cls_q);
	end

	// scan and insertion helpers
	logic ins_lt, ok_s1, find_upd, scan_re, sup_done, kill;
	logic signed [GW-1:0] la, ra, lb, rb, ta, ba, tb, bb, ow_c, oh_c;
	logic signed [LW-1:0] uni, lhs, rhs;

	assign ins_lt   = rdata.key < new_q.key;
	assign ok_s1    = alive_q[j_s1] && (rdata.cidx == cls_q);
	assign find_upd = v_s1 && ok_s1 && (!found_q || rdata.obj > best_q.obj);
	assign scan_re  = (state_q == S_FIND || state_q == S_SUP) && (j_q < count_q);
	assign sup_done = (j_q == count_q) && !v_s1 && !v_s2 && !v_s3;

	always_comb begin
		la   = (GW'(rdata.x) <<< 1) - GW'(rdata.w);
		ra   = (GW'(rdata.x) <<< 1) + GW'(rdata.w);
		lb   = (GW'(best_q.x) <<< 1) - GW'(best_q.w);
		rb   = (GW'(best_q.x) <<< 1) + GW'(best_q.w);
		ta   = (GW'(rdata.y) <<< 1) - GW'(rdata.h);
		ba   = (GW'(rdata.y) <<< 1) + GW'(rdata.h);
		tb   = (GW'(best_q.y) <<< 1) - GW'(best_q.h);
		bb   = (GW'(best_q.y) <<< 1) + GW'(best_q.h);
		ow_c = ((ra < rb) ? ra : rb) - ((la > lb) ? la : lb);
		oh_c = ((ba < bb) ? ba : bb) - ((ta > tb) ? ta : tb);
		uni  = LW'(sum_s3) - LW'(inter_s3);
		lhs  = LW'(inter_s3) <<< 8;
		rhs  = signed'(LW'(nms_q)) * uni;
		kill = v_s3 && ok_s3 && !uni[LW-1] && (uni != '0) && (lhs > rhs);
	end

	// box ram port control
	always_comb begin
		re    = 1'b0;
		raddr = j_q[AW-1:0];
		unique case (state_q)
			S_INS_RD: begin
				re    = (k_q != '0);
				raddr = AW'(k_q - CNTW'(1));
			end
			S_NEXT_I: begin
				re    = (i_q < count_q) && alive_q[i_q[AW-1:0]];
				raddr = i_q[AW-1:0];
			end
			S_FIND, S_SUP: begin
				re    = scan_re;
				raddr = j_q[AW-1:0];
			end
			default: begin
				re    = 1'b0;
			end
		endcase
		we    = (state_q == S_INS_RD && k_q == '0) || (state_q == S_INS_CMP);
		waddr = k_q[AW-1:0];
		wdata = (state_q == S_INS_CMP && ins_lt) ? rdata : new_q;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_acc) begin
					if (anchor_end && pass_conf && !full)
						state_d = S_KEY;
					else if (last_in_frame)
						state_d = S_NMS_INIT;
				end
			end
			S_KEY: state_d = S_INS_RD;
			S_INS_RD: begin
				if (k_q == '0)
					state_d = pend_q ? S_NMS_INIT : S_LOAD;
				else
					state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				if (ins_lt)
					state_d = S_INS_RD;
				else
					state_d = pend_q ? S_NMS_INIT : S_LOAD;
			end
			S_NMS_INIT: state_d = (count_q == '0) ? S_EMIT : S_NEXT_I;
			S_NEXT_I: begin
				if (i_q == count_q)
					state_d = pass_q ? S_DONE : S_NMS_INIT;
				else if (alive_q[i_q[AW-1:0]])
					state_d = S_CLS;
			end
			S_CLS: state_d = S_FIND;
			S_FIND: begin
				if (j_q == count_q && !v_s1)
					state_d = S_FIND_END;
			end
			S_FIND_END: begin
				if (!found_q)
					state_d = S_NEXT_I;
				else
					state_d = pass_q ? S_EMIT : S_SUP;
			end
			S_EMIT: begin
				if (out_ready)
					state_d = out_last_q ? S_DONE : S_SUP;
			end
			S_SUP: begin
				if (sup_done)
					state_d = S_FIND;
			end
			S_DONE: state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_LOAD;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q      <= CONF_RESET;
			nms_q       <= NMS_RESET;
			nch_q       <= NCH_RESET;
			angle_q     <= 1'b0;
			for (int g = 0; g < GEO_FIELDS; g++)
				geo_q[g] <= '0;
			best_cls_q  <= '0;
			best_bin_q  <= '0;
			reg_q       <= '0;
			cls_idx_q   <= '0;
			bin_idx_q   <= '0;
			cls_seen_q  <= 1'b0;
			bin_seen_q  <= 1'b0;
			chan_q      <= '0;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			n_q         <= '0;
			tot_q       <= '0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
			pass_q      <= 1'b0;
			found_q     <= 1'b0;
			alive_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CONF:  conf_q  <= cfg_data;
					CFG_NMS:   nms_q   <= cfg_data;
					CFG_NCH:   nch_q   <= cfg_data[NCH_WIDTH-1:0];
					CFG_ANGLE: angle_q <= cfg_data[0];
					default:   angle_q <= angle_q;
				endcase
			end

			v_s1 <= scan_re;
			v_s2 <= v_s1 && ok_s1 && (state_q == S_SUP);
			v_s3 <= v_s2;

			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						pend_q <= last_in_frame;
						if (c10 < 10'(GEO_FIELDS)) begin
							geo_q[chan_q[2:0]] <= channel_value;
						end else if (in_bin) begin
							if (!bin_seen_q || channel_value > best_bin_q) begin
								best_bin_q <= channel_value;
								bin_idx_q  <= 3'(c10 + 10'(ANGLE_TAIL) - n10);
								bin_seen_q <= 1'b1;
							end
						end else if (in_reg) begin
							reg_q <= channel_value;
						end else if (!cls_seen_q || channel_value > best_cls_q) begin
							best_cls_q <= channel_value;
							cls_idx_q  <= CIW'(c10 - 10'(GEO_FIELDS));
							cls_seen_q <= 1'b1;
						end
						if (anchor_end && pass_conf && full)
							ovf_q <= 1'b1;
						if (anchor_end || last_in_frame)
							chan_q <= '0;
						else
							chan_q <= chan_q + CW'(1);
						// drop the anchor when it ends without going to insertion, or when the frame ends mid-anchor
						if ((anchor_end && !(pass_conf && !full)) ||
								(!anchor_end && last_in_frame)) begin
							for (int g = 0; g < GEO_FIELDS; g++)
								geo_q[g] <= '0;
							best_cls_q <= '0;
							best_bin_q <= '0;
							reg_q      <= '0;
							cls_idx_q  <= '0;
							bin_idx_q  <= '0;
							cls_seen_q <= 1'b0;
							bin_seen_q <= 1'b0;
						end
					end
				end
				S_KEY: begin
					k_q <= count_q;
					for (int g = 0; g < GEO_FIELDS; g++)
						geo_q[g] <= '0;
					best_cls_q <= '0;
					best_bin_q <= '0;
					reg_q      <= '0;
					cls_idx_q  <= '0;
					bin_idx_q  <= '0;
					cls_seen_q <= 1'b0;
					bin_seen_q <= 1'b0;
				end
				S_INS_RD: begin
					if (k_q == '0)
						count_q <= count_q + CNTW'(1);
				end
				S_INS_CMP: begin
					if (ins_lt)
						k_q <= k_q - CNTW'(1);
					else
						count_q <= count_q + CNTW'(1);
				end
				S_NMS_INIT: begin
					alive_q <= '1;
					i_q     <= '0;
					n_q     <= '0;
					if (count_q == '0)
						out_valid_q <= 1'b1;
				end
				S_NEXT_I: begin
					if (i_q == count_q) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							if (n_q > NW'(RESULT_CAP)) begin
								ovf_q <= 1'b1;
								tot_q <= NW'(RESULT_CAP);
							end else begin
								tot_q <= n_q;
							end
						end
					end else if (!alive_q[i_q[AW-1:0]]) begin
						i_q <= i_q + CNTW'(1);
					end
				end
				S_CLS: begin
					j_q     <= '0;
					found_q <= 1'b0;
				end
				S_FIND: begin
					if (scan_re)
						j_q <= j_q + CNTW'(1);
					if (find_upd)
						found_q <= 1'b1;
				end
				S_FIND_END: begin
					j_q <= '0;
					if (!found_q) begin
						i_q <= i_q + CNTW'(1);
					end else begin
						alive_q[best_idx_q] <= 1'b0;
						if (pass_q) begin
							out_valid_q <= 1'b1;
							n_q         <= n_q + NW'(1);
						end else if (n_q <= NW'(RESULT_CAP)) begin
							n_q <= n_q + NW'(1);
						end
					end
				end
				S_EMIT: begin
					if (out_ready)
						out_valid_q <= 1'b0;
				end
				S_SUP: begin
					if (scan_re)
						j_q <= j_q + CNTW'(1);
					if (kill)
						alive_q[j_s3] <= 1'b0;
					if (sup_done) begin
						j_q     <= '0;
						found_q <= 1'b0;
					end
				end
				S_DONE: begin
					count_q <= '0;
					chan_q  <= '0;
					ovf_q   <= 1'b0;
					pend_q  <= 1'b0;
					pass_q  <= 1'b0;
				end
				default: begin
					pass_q <= pass_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		j_s1     <= j_q[AW-1:0];
		j_s2     <= j_s1;
		j_s3     <= j_s2;
		ow_s2    <= ow_c;
		oh_s2    <= oh_c;
		aj_s2    <= KW'(rdata.w) * KW'(rdata.h);
		ok_s2    <= ok_s1;
		ok_s3    <= ok_s2;
		inter_s3 <= (ow_s2 <= 0 || oh_s2 <= 0) ? '0 : PW'(ow_s2) * PW'(oh_s2);
		sum_s3   <= (PW'(aj_s2) <<< 2) + (PW'(area_q) <<< 2);

		if (state_q == S_KEY) begin
			new_q.x    <= geo_q[0];
			new_q.y    <= geo_q[1];
			new_q.w    <= geo_q[2];
			new_q.h    <= geo_q[3];
			new_q.obj  <= geo_q[4];
			new_q.cls  <= best_cls_q;
			new_q.ang  <= angle_q ? ang_sat : '0;
			new_q.cidx <= cls_idx_q;
			new_q.key  <= key_c;
		end
		if (state_q == S_CLS)
			cls_q <= rdata.cidx;
		if (state_q == S_FIND && find_upd) begin
			best_q     <= rdata;
			best_idx_q <= j_s1;
		end
		if (state_q == S_FIND_END)
			area_q <= KW'(best_q.w) * KW'(best_q.h);

		if (state_q == S_NMS_INIT && count_q == '0) begin
			out_q      <= '0;
			out_none_q <= 1'b1;
			out_ovf_q  <= 1'b0;
			out_last_q <= 1'b1;
		end else if (state_q == S_FIND_END && found_q && pass_q) begin
			out_q      <= best_q;
			out_none_q <= 1'b0;
			out_ovf_q  <= ovf_q;
			out_last_q <= (n_q == tot_q - NW'(1));
		end
	end

	assign in_ready    = (state_q == S_LOAD);
	assign out_valid   = out_valid_q;
	assign box_x       = out_q.x;
	assign box_y       = out_q.y;
	assign box_w       = out_q.w;
	assign box_h       = out_q.h;
	assign objectness  = out_q.obj;
	assign class_index = out_q.cidx[CLASS_WIDTH-1:0];
	assign class_score = out_q.cls;
	assign angle_deg   = out_q.ang;
	assign none_found  = out_none_q;
	assign overflow    = out_ovf_q;
	assign last_result = out_last_q;

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready)
		else $error("input taken while a result is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_BOXES))
		else $error("box count beyond store depth");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && out_last_q) |=> (state_q == S_DONE))
		else $error("frame did not close after last result");

	a_scan_idle_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!v_s2 && !v_s3))
		else $error("suppression pipeline busy while loading");

endmodule
`default_nettype wire
